>>> hdl/fpc_pkg.sv
// fpc_pkg: shared types and constants of the framed packet checker
// no dependencies; imported by every module of the block
package fpc_pkg;

  localparam logic [7:0] LeadAck = 8'h06;
  localparam logic [7:0] LeadBs  = 8'h08;
  localparam logic [7:0] CharStx = 8'h02;
  localparam logic [7:0] CharEtx = 8'h03;

  localparam logic [15:0] MinLength     = 16'd9;
  localparam logic [15:0] MaxLengthInit = 16'd2048;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFormat   = 2'd1,
    StatusChecksum = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] packet_length;
    logic        lead_is_backspace;
    logic [7:0]  computed_sum;
  } result_t;

endpackage

>>> hdl/fpc_front.sv
// fpc_front: byte parser of the framed packet checker, holds frame state
// and the max_length register; depends on fpc_pkg
module fpc_front
  import fpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  output logic        in_ready_o,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output result_t     push_data_o
);

  logic [15:0] max_length_q;
  logic [15:0] pos_q, pos_d;
  logic [15:0] decl_q, decl_d;
  logic [7:0]  sum_q, sum_d;
  logic        lead_q, lead_d;
  logic [7:0]  high_q, high_d;
  logic        mismatch_q, mismatch_d;
  logic        bad_q, bad_d;

  logic        accept;
  logic [15:0] len;
  logic [16:0] pos_plus2;
  logic [16:0] decl_ext;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len        = {high_q, in_byte_i};
  assign pos_plus2  = {1'b0, pos_q} + 17'd2;
  assign decl_ext   = {1'b0, decl_q};

  always_comb begin
    pos_d       = pos_q;
    decl_d      = decl_q;
    sum_d       = sum_q;
    lead_d      = lead_q;
    high_d      = high_q;
    mismatch_d  = mismatch_q;
    bad_d       = bad_q;
    push_o      = 1'b0;
    push_data_o = '{status: StatusOk, packet_length: decl_q,
                    lead_is_backspace: lead_q, computed_sum: sum_q};
    if (accept) begin
      case (pos_q)
        16'd0: begin
          lead_d = (in_byte_i == LeadBs);
          bad_d  = !((in_byte_i == LeadAck) || (in_byte_i == LeadBs));
          sum_d  = in_byte_i;
          pos_d  = 16'd1;
        end
        16'd1: begin
          bad_d = bad_q || (in_byte_i != CharStx);
          sum_d = sum_q + in_byte_i;
          pos_d = 16'd2;
        end
        16'd2: begin
          high_d = in_byte_i;
          sum_d  = sum_q + in_byte_i;
          pos_d  = 16'd3;
        end
        16'd3: begin
          if (bad_q || (len < MinLength) || (len > max_length_q)) begin
            push_o      = 1'b1;
            push_data_o = '{status: StatusFormat, packet_length: 16'd0,
                            lead_is_backspace: lead_q, computed_sum: 8'd0};
            pos_d      = '0;
            decl_d     = '0;
            sum_d      = '0;
            lead_d     = 1'b0;
            high_d     = '0;
            mismatch_d = 1'b0;
            bad_d      = 1'b0;
          end else begin
            decl_d = len;
            sum_d  = sum_q + in_byte_i;
            pos_d  = 16'd4;
          end
        end
        default: begin
          if (pos_plus2 < decl_ext) begin
            sum_d = sum_q + in_byte_i;
            pos_d = pos_q + 16'd1;
          end else if (pos_plus2 == decl_ext) begin
            // checksum byte: sum stays frozen from here on
            mismatch_d = (in_byte_i != sum_q);
            pos_d      = pos_q + 16'd1;
          end else begin
            push_o = 1'b1;
            if (in_byte_i != CharEtx) begin
              push_data_o.status = StatusFormat;
            end else if (mismatch_q) begin
              push_data_o.status = StatusChecksum;
            end else begin
              push_data_o.status = StatusOk;
            end
            pos_d      = '0;
            decl_d     = '0;
            sum_d      = '0;
            lead_d     = 1'b0;
            high_d     = '0;
            mismatch_d = 1'b0;
            bad_d      = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthInit;
      pos_q        <= '0;
      decl_q       <= '0;
      sum_q        <= '0;
      lead_q       <= 1'b0;
      high_q       <= '0;
      mismatch_q   <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_length_q <= cfg_data_i;
      end
      pos_q      <= pos_d;
      decl_q     <= decl_d;
      sum_q      <= sum_d;
      lead_q     <= lead_d;
      high_q     <= high_d;
      mismatch_q <= mismatch_d;
      bad_q      <= bad_d;
    end
  end

endmodule

>>> hdl/fpc_queue.sv
// fpc_queue: short result queue between parser and output stage
// depends on fpc_pkg for the result type
module fpc_queue
  import fpc_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  result_t           entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/fpc_back.sv
// fpc_back: output register stage that drains the result queue
// depends on fpc_pkg for the result type
module fpc_back
  import fpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    empty_i,
  input  result_t pop_data_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q;
  result_t data_q;

  // refill whenever the register is empty or being taken this cycle
  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= pop_data_i;
    end
  end

endmodule

>>> hdl/framed_packet_checker_unit.sv
// framed packet checker: one byte per cycle; the result of a frame is registered in
// the queue and then in the output register; queue of QueueDepth results
// input stalls only when the queue is full; configuration always ready
// asynchronous active-low reset clears frame state, queue and output valid,
// and sets max_length to 2048
// depends on fpc_pkg, fpc_front, fpc_queue, fpc_back
module framed_packet_checker_unit
  import fpc_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] packet_length, [23:16] computed_sum
  output logic [2:0]  m_axis_tuser_o,   // [1:0] status, [2] lead_is_backspace
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i        // max_length
);

  logic    push, full, pop, empty;
  result_t push_data, pop_data, out_data;

  assign cfg_ready_o = 1'b1;

  fpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_byte_i    (s_axis_tdata_i),
    .in_ready_o   (s_axis_tready_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  fpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  fpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = {out_data.computed_sum, out_data.packet_length};
  assign m_axis_tuser_o = {out_data.lead_is_backspace, 2'(out_data.status)};

endmodule

>>> hdl/fpc_checker.sv
// fpc_checker: port-level assertions for the framed packet checker, with bind
// depends on fpc_pkg and framed_packet_checker_unit
module fpc_checker
  import fpc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        cfg_ready_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[1:0] == StatusOk)
      || (m_axis_tuser_o[1:0] == StatusFormat)
      || (m_axis_tuser_o[1:0] == StatusChecksum))
    else $error("undefined status code");

  // rejected header carries no sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:0] == 16'd0) |->
      (m_axis_tuser_o[1:0] == StatusFormat) && (m_axis_tdata_o[23:16] == 8'd0))
    else $error("zero length result not a clean header reject");

  // an ok or checksum result always has at least the minimum length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] != StatusFormat) |->
      (m_axis_tdata_o[15:0] >= MinLength))
    else $error("ok or checksum result with short length");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind framed_packet_checker_unit fpc_checker u_fpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .cfg_ready_o     (cfg_ready_o)
);

>>> tb/sv/framed_packet_checker_unit_tb.sv
// framed_packet_checker_unit_tb: self-checking testbench of the framed packet checker
// predicts each status item from the accepted byte stream; needs fpc_pkg and the unit
`timescale 1ns / 1ps

module framed_packet_checker_unit_tb;
  import fpc_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // [7:0] data_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;           // [15:0] packet_length, [23:16] computed_sum
  logic [2:0]  m_axis_tuser_o;           // [1:0] status, [2] lead_is_backspace
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = 16'h0000;    // max_length

  framed_packet_checker_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // predicted checker state
  logic [15:0] max_length_q = MaxLengthInit;
  logic [15:0] frame_pos = '0;
  logic [15:0] frame_len = '0;
  logic [7:0]  frame_sum = '0;
  logic        frame_is_bs = 1'b0;
  logic [7:0]  len_high = '0;
  logic        sum_bad = 1'b0;
  logic        header_bad = 1'b0;

  result_t pending_reports[$];
  int      error_count = 0;
  int      bytes_sent = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 17;
  int      recv_idle_pct = 46;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, exp_val);
    error_count++;
  endtask

  task automatic restart_frame();
    frame_pos = '0;
    frame_len = '0;
    frame_sum = '0;
    frame_is_bs = 1'b0;
    len_high = '0;
    sum_bad = 1'b0;
    header_bad = 1'b0;
  endtask

  task automatic predict_frame_byte(input logic [7:0] b);
    result_t     rep;
    logic [15:0] len;
    logic        emit;
    emit = 1'b0;
    rep = '0;
    case (frame_pos)
      16'd0: begin
        frame_is_bs = (b == LeadBs);
        header_bad = !(b == LeadAck || b == LeadBs);
        frame_sum = b;
        frame_pos = 16'd1;
      end
      16'd1: begin
        if (b != CharStx) header_bad = 1'b1;
        frame_sum = frame_sum + b;
        frame_pos = 16'd2;
      end
      16'd2: begin
        len_high = b;
        frame_sum = frame_sum + b;
        frame_pos = 16'd3;
      end
      16'd3: begin
        len = {len_high, b};
        if (header_bad || len < MinLength || len > max_length_q) begin
          rep.status = StatusFormat;
          rep.packet_length = '0;
          rep.lead_is_backspace = frame_is_bs;
          rep.computed_sum = '0;
          emit = 1'b1;
        end else begin
          frame_len = len;
          frame_sum = frame_sum + b;
          frame_pos = 16'd4;
        end
      end
      default: begin
        if ({1'b0, frame_pos} + 17'd2 < {1'b0, frame_len}) begin
          frame_sum = frame_sum + b;
          frame_pos = frame_pos + 16'd1;
        end else if ({1'b0, frame_pos} + 17'd2 == {1'b0, frame_len}) begin
          // checksum byte: sum is frozen from here on
          sum_bad = (b != frame_sum);
          frame_pos = frame_pos + 16'd1;
        end else begin
          // missing etx wins over a bad checksum
          if (b != CharEtx) rep.status = StatusFormat;
          else if (sum_bad) rep.status = StatusChecksum;
          else rep.status = StatusOk;
          rep.packet_length = frame_len;
          rep.lead_is_backspace = frame_is_bs;
          rep.computed_sum = frame_sum;
          emit = 1'b1;
        end
      end
    endcase
    if (emit) begin
      pending_reports.push_back(rep);
      restart_frame();
    end
  endtask

  // accepted items on every channel, in order: config, input byte, result
  always @(posedge clk_i) begin
    result_t exp_rep;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) max_length_q = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o) predict_frame_byte(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected item", {13'b0, m_axis_tuser_o}, 16'h0);
        end else begin
          exp_rep = pending_reports.pop_front();
          if (m_axis_tuser_o[1:0] != exp_rep.status)
            report_mismatch("status", 16'(m_axis_tuser_o[1:0]), 16'(exp_rep.status));
          if (m_axis_tdata_o[15:0] != exp_rep.packet_length)
            report_mismatch("packet_length", m_axis_tdata_o[15:0], exp_rep.packet_length);
          if (m_axis_tuser_o[2] != exp_rep.lead_is_backspace)
            report_mismatch("lead_is_backspace", 16'(m_axis_tuser_o[2]),
                            16'(exp_rep.lead_is_backspace));
          if (m_axis_tdata_o[23:16] != exp_rep.computed_sum)
            report_mismatch("computed_sum", 16'(m_axis_tdata_o[23:16]),
                            16'(exp_rep.computed_sum));
        end
      end
      // idle only counts as progress when nothing is offered or owed
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid_i && s_axis_tready_o)
          || (m_axis_tvalid_o && m_axis_tready_i)
          || (!s_axis_tvalid_i && !cfg_valid_i && pending_reports.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] lead, input logic [7:0] stx,
                             input logic [15:0] len);
    send_byte(lead);
    send_byte(stx);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // whole packet; sum_delta spoils the checksum, etx_byte may be wrong
  task automatic send_packet(input logic [7:0] lead, input logic [15:0] len,
                             input logic [7:0] sum_delta, input logic [7:0] etx_byte);
    logic [7:0] sum;
    logic [7:0] b;
    sum = lead + CharStx + len[15:8] + len[7:0];
    send_header(lead, CharStx, len);
    for (int i = 0; i < int'(len) - 6; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      send_byte(b);
    end
    send_byte(sum + sum_delta);
    send_byte(etx_byte);
  endtask

  // let every result drain and the block go quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] wrong_etx();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CharEtx) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] wrong_lead();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == LeadAck || b == LeadBs) b = b ^ 8'h80;
    return b;
  endfunction

  task automatic test_frame_outcomes();
    send_packet(LeadAck, 16'd9, 8'h00, CharEtx);
    send_packet(LeadBs, 16'd9, 8'h01, CharEtx);
    send_packet(LeadAck, 16'd9, 8'h00, 8'hFF);
    send_packet(LeadBs, 16'd9, 8'hFF, 8'h00);
  endtask

  task automatic test_header_rejects();
    send_header(8'hFF, CharStx, 16'd20);
    send_header(LeadBs, 8'h03, 16'd20);
    send_header(LeadAck, CharStx, 16'd8);
    send_header(LeadBs, CharStx, MaxLengthInit + 16'd1);
    send_header(8'h00, 8'hFF, 16'hFFFF);
    send_header(LeadAck, CharStx, 16'h0000);
  endtask

  task automatic test_length_limits();
    write_max_length(16'd9);
    send_packet(LeadAck, 16'd9, 8'h00, CharEtx);
    send_header(LeadAck, CharStx, 16'd10);
    // a limit below the minimum length rejects every header
    write_max_length(16'd8);
    send_header(LeadAck, CharStx, 16'd9);
    write_max_length(16'd0);
    send_header(LeadBs, CharStx, 16'd0);
    // a packet exactly at the limit passes, one byte more is rejected
    write_max_length(16'd300);
    send_packet(LeadBs, 16'd300, 8'h00, CharEtx);
    send_header(LeadAck, CharStx, 16'd301);
    write_max_length(16'hFFFF);
    send_header(LeadAck, CharStx, 16'd8);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [15:0] limit, input int item_count);
    int          stop_at;
    int          kind;
    int          cap;
    logic [7:0]  lead;
    logic [15:0] len;
    write_max_length(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + item_count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      lead = $urandom_range(1) ? LeadBs : LeadAck;
      cap = (limit < 16'd64) ? int'(limit) : 64;
      if ($urandom_range(99) < 3) cap = (limit < 16'd600) ? int'(limit) : 600;
      len = (cap < 9) ? 16'd9 : 16'($urandom_range(9, cap));
      if (len > limit) begin
        send_header(lead, CharStx, len);
      end else if (kind < 60) begin
        send_packet(lead, len, 8'h00, CharEtx);
      end else if (kind < 70) begin
        send_packet(lead, len, 8'($urandom_range(1, 255)), CharEtx);
      end else if (kind < 78) begin
        send_packet(lead, len, 8'h00, wrong_etx());
      end else if (kind < 82) begin
        send_packet(lead, len, 8'($urandom_range(1, 255)), wrong_etx());
      end else if (kind < 88) begin
        send_header(wrong_lead(), CharStx, len);
      end else if (kind < 93) begin
        send_header(lead, $urandom_range(1) ? 8'($urandom_range(255)) ^ CharStx | 8'h10
                    : 8'h00, len);
      end else if (kind < 98) begin
        if (limit == 16'hFFFF || $urandom_range(1))
          send_header(lead, CharStx, 16'($urandom_range(0, 8)));
        else
          send_header(lead, CharStx, 16'($urandom_range(int'(limit) + 1, 65535)));
      end else begin
        // raw noise, almost always a rejected header
        send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_frame_outcomes();
    test_header_rejects();
    test_length_limits();
    test_random_traffic(17, 46, MaxLengthInit, 440);
    test_random_traffic(46, 17, 16'($urandom_range(9, 200)), 440);
    test_random_traffic(0, 0, 16'hFFFF, 440);
    settle();
    if (error_count == 0 && pending_reports.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
